// File: hw/rtl/sfg_pkg.sv
// Shared types and constants of the SBUS frame generator with stick slew.
package sfg_pkg;

	localparam int CH_W        = 11;
	localparam int NUM_CH      = 16;
	localparam int NUM_STICK   = 4;
	localparam int NUM_HELD    = 4;
	localparam int DATA_BYTES  = 22;
	localparam int DUR_W       = 16;
	localparam int COUNT_W     = 14;
	localparam int IDX_W       = 5;
	localparam int CFG_IDX_W   = 3;

	localparam int TICK_PERIOD_MS_DEF = 5;

	localparam logic [7:0]         SYNC_BYTE  = 8'h0F;
	localparam logic [7:0]         ZERO_BYTE  = 8'h00;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [IDX_W-1:0]   FIRST_IDX  = 5'd0;
	localparam logic [IDX_W-1:0]   LAST_DATA  = 5'd22;
	localparam logic [IDX_W-1:0]   LAST_IDX   = 5'd24;

	// item kinds
	localparam logic [1:0] KIND_TICK     = 2'd0;
	localparam logic [1:0] KIND_MOVE     = 2'd1;
	localparam logic [1:0] KIND_OVERRIDE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUX9    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AUX10   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEW    = 3'd4;

	localparam logic [CH_W-1:0] RST_NEUTRAL = 11'd992;
	localparam logic [CH_W-1:0] RST_LOW     = 11'd192;
	localparam logic [CH_W-1:0] RST_SLEW    = 11'd80;

	typedef struct packed {
		logic [1:0]       kind;
		logic [CH_W-1:0]  left_x;
		logic [CH_W-1:0]  left_y;
		logic [CH_W-1:0]  right_x;
		logic [CH_W-1:0]  right_y;
		logic [DUR_W-1:0] move_time;
		logic [3:0]       channel_index;
		logic [CH_W-1:0]  mode_value;
		logic [CH_W-1:0]  pulse_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       frame_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last_byte;
	} frame_t;

endpackage

// File: hw/rtl/sbus_frame_generator_with_slew.sv
// SBUS frame generator: stick slewing, move timing and 25-byte frame output.
//
// Usage
//   cmd channel (cmd_valid / cmd_stall / cmd): one item per tick, move or override.
//   res channel (res_valid / res_stall / res): one item per frame byte, index 0..24,
//   last_byte set on byte 24.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; write
//   only while the block is idle and all frame bytes have been taken.
// Sequence and throughput
//   tick:     slewing of the four sticks (one stick per cycle through the shared slew unit),
//             then 25 bytes, one per cycle when res is not stalled.
//   move:     the duration is divided by the tick period with a reciprocal multiply.
//   override: 25 bytes.
//   cmd_stall is high for the whole of that work; the next item is taken from the cycle
//   after the last byte enters the output register, even if that byte is still stalled.
// Reset
//   Registers take their defaults, sticks and channels 4 and 7 sit at 992, channels 5
//   and 6 at 192, the move count is zero and no byte is pending.
// Stalls
//   A stalled byte holds in the output register and the sequencer waits for it.
module sbus_frame_generator_with_slew
	import sfg_pkg::*;
#(
	parameter int TICK_PERIOD_MS = TICK_PERIOD_MS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output frame_t               res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CH_W-1:0]      cfg_data
);

	// reciprocal of the tick period, exact for every duration of DUR_W bits
	localparam int RECIP_SH = DUR_W + $clog2(TICK_PERIOD_MS);
	localparam int RECIP_W  = DUR_W + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(TICK_PERIOD_MS) - 64'd1) / 64'(TICK_PERIOD_MS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SLEW,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CH_W-1:0] neutral_q, aux9_q, aux10_q, slew_step_q;

	// stored channels: sticks 0..3 and channels 4..7
	logic [NUM_STICK-1:0][CH_W-1:0] stick_q;
	logic [NUM_HELD-1:0][CH_W-1:0]  held_q;
	logic [NUM_STICK-1:0][CH_W-1:0] tgt_q;
	logic [COUNT_W-1:0]             count_q;

	// sequencer
	logic [1:0]        slew_idx_q;
	logic [DUR_W-1:0]  dq_q;
	logic [IDX_W-1:0]  byte_idx_q;

	// override frame
	logic             ovr_q;
	logic [3:0]       ovr_idx_q;
	logic [CH_W-1:0]  ovr_mode_q, ovr_pulse_q;

	logic   res_valid_q;
	frame_t res_q;

	logic cmd_take, res_free;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// shared slew unit: one stick per cycle
	logic [CH_W-1:0] cur, goal, d, stepped, slewed;
	logic            up;

	always_comb begin
		cur     = stick_q[slew_idx_q];
		goal    = (count_q != '0) ? tgt_q[slew_idx_q] : neutral_q;
		up      = goal > cur;
		d       = up ? goal - cur : cur - goal;
		stepped = up ? cur + slew_step_q : cur - slew_step_q;
		slewed  = (slew_step_q == '0 || d <= slew_step_q) ? goal : stepped;
	end

	// duration divided by the tick period
	logic [DUR_W+RECIP_W-1:0] prod;
	logic [DUR_W-1:0]         quot;

	always_comb begin
		prod = {{RECIP_W{1'b0}}, dq_q} * {{DUR_W{1'b0}}, RECIP};
		quot = DUR_W'(prod >> RECIP_SH);
	end

	// channel vector and byte select
	logic [NUM_CH-1:0][CH_W-1:0]     ch_vec;
	logic [DATA_BYTES-1:0][7:0]      data_bytes;
	logic [IDX_W-1:0]                data_sel;
	logic [7:0]                      byte_val;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			ch_vec[i] = neutral_q;
		end
		for (int i = 0; i < NUM_STICK; i++) begin
			ch_vec[i] = stick_q[i];
		end
		for (int i = 0; i < NUM_HELD; i++) begin
			ch_vec[NUM_STICK + i] = held_q[i];
		end
		ch_vec[8] = aux9_q;
		ch_vec[9] = aux10_q;
		if (ovr_q) begin
			ch_vec[4]         = ovr_mode_q;
			ch_vec[ovr_idx_q] = ovr_pulse_q;
		end
	end

	assign data_bytes = ch_vec;
	assign data_sel   = byte_idx_q - 5'd1;

	always_comb begin
		if (byte_idx_q == FIRST_IDX) begin
			byte_val = SYNC_BYTE;
		end else if (byte_idx_q <= LAST_DATA) begin
			byte_val = data_bytes[data_sel];
		end else begin
			byte_val = ZERO_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neutral_q   <= RST_NEUTRAL;
			aux9_q      <= RST_NEUTRAL;
			aux10_q     <= RST_NEUTRAL;
			slew_step_q <= RST_SLEW;
			for (int i = 0; i < NUM_STICK; i++) begin
				stick_q[i] <= RST_NEUTRAL;
				tgt_q[i]   <= RST_NEUTRAL;
			end
			held_q[0]   <= RST_NEUTRAL;
			held_q[1]   <= RST_LOW;
			held_q[2]   <= RST_LOW;
			held_q[3]   <= RST_NEUTRAL;
			count_q     <= '0;
			slew_idx_q  <= '0;
			dq_q        <= '0;
			byte_idx_q  <= '0;
			ovr_q       <= 1'b0;
			ovr_idx_q   <= '0;
			ovr_mode_q  <= '0;
			ovr_pulse_q <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// drop a byte once it has been taken; while emitting the sequencer refills
			if (res_valid_q && !res_stall && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NEUTRAL: neutral_q   <= cfg_data;
					// the low value only sets channels 5 and 6 at reset
					CFG_LOW:     ;
					CFG_AUX9:    aux9_q      <= cfg_data;
					CFG_AUX10:   aux10_q     <= cfg_data;
					CFG_SLEW:    slew_step_q <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						case (cmd.kind)
							KIND_TICK: begin
								ovr_q      <= 1'b0;
								slew_idx_q <= '0;
								state_q    <= ST_SLEW;
							end
							KIND_MOVE: begin
								tgt_q[0]  <= cmd.right_x;
								tgt_q[1]  <= cmd.right_y;
								tgt_q[2]  <= cmd.left_y;
								tgt_q[3]  <= cmd.left_x;
								dq_q      <= cmd.move_time;
								state_q   <= ST_DIV;
							end
							KIND_OVERRIDE: begin
								ovr_q       <= 1'b1;
								ovr_idx_q   <= cmd.channel_index;
								ovr_mode_q  <= cmd.mode_value;
								ovr_pulse_q <= cmd.pulse_value;
								byte_idx_q  <= '0;
								state_q     <= ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					// saturate long movements
					count_q <= (quot[DUR_W-1:COUNT_W] != '0) ? COUNT_MAX
					           : quot[COUNT_W-1:0];
					state_q <= ST_IDLE;
				end
				ST_SLEW: begin
					stick_q[slew_idx_q] <= slewed;
					slew_idx_q          <= slew_idx_q + 1'b1;
					if (slew_idx_q == 2'(NUM_STICK - 1)) begin
						if (count_q != '0) begin
							count_q <= count_q - 1'b1;
						end
						byte_idx_q <= '0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						res_valid_q      <= 1'b1;
						res_q.frame_byte <= byte_val;
						res_q.byte_index <= byte_idx_q;
						res_q.last_byte  <= (byte_idx_q == LAST_IDX);
						byte_idx_q       <= byte_idx_q + 1'b1;
						if (byte_idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the final flag marks the last byte and nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.last_byte == (res.byte_index == LAST_IDX)))
		else $error("last_byte out of step with byte_index");

	// every frame opens with the sync byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.byte_index == FIRST_IDX |-> res.frame_byte == SYNC_BYTE)
		else $error("frame does not open with sync byte");

	// a tick uses up one frame of a running movement
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SLEW && slew_idx_q == 2'(NUM_STICK - 1) && count_q != '0
		|=> count_q == $past(count_q) - 1'b1)
		else $error("move count not decremented on tick");

	// a stalled byte is never overwritten by the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && res_valid_q && res_stall |=> $stable(byte_idx_q))
		else $error("sequencer advanced over a stalled byte");

endmodule
